FILE: rtl/core/lra_pkg.sv
// ----------------------------------------------------------------------------
// lra_pkg: shared types and constants of the LED ring animation engine
// Pattern codes, register indexes, hold times, scale denominators and the
// job bundle passed from the frame sequencer to the colour scalers.
// ----------------------------------------------------------------------------
`default_nettype none

package lra_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_LAMP_ON    = 3'd0,
    CFG_PATTERN    = 3'd1,
    CFG_BASE_RED   = 3'd2,
    CFG_BASE_GREEN = 3'd3,
    CFG_BASE_BLUE  = 3'd4,
    CFG_BRIGHTNESS = 3'd5
  } cfg_idx_e;

  // Pattern codes
  localparam logic [3:0] PAT_SOLID   = 4'd1;
  localparam logic [3:0] PAT_SPIN    = 4'd2;
  localparam logic [3:0] PAT_BREATHE = 4'd4;

  // Frame hold times in milliseconds
  localparam logic [5:0] HOLD_DARK    = 6'd50;
  localparam logic [5:0] HOLD_SOLID   = 6'd50;
  localparam logic [5:0] HOLD_SPIN    = 6'd60;
  localparam logic [5:0] HOLD_BREATHE = 6'd25;

  // Spinner tail and breathe level limits
  localparam logic [6:0] TAIL_LEN   = 7'd5;
  localparam logic [6:0] LEVEL_MAX  = 7'd100;
  localparam logic [6:0] LEVEL_STEP = 7'd2;

  // Scale denominators: 255 times the weight's full scale
  localparam logic [14:0] DEN_UNIT    = 15'd255;
  localparam logic [14:0] DEN_SPIN    = 15'd1275;
  localparam logic [14:0] DEN_BREATHE = 15'd25500;

  // Reset values of the configuration registers
  localparam logic       RST_LAMP_ON    = 1'b1;
  localparam logic [3:0] RST_PATTERN    = PAT_SPIN;
  localparam logic [7:0] RST_BASE_RED   = 8'd0;
  localparam logic [7:0] RST_BASE_GREEN = 8'd0;
  localparam logic [7:0] RST_BASE_BLUE  = 8'd255;
  localparam logic [7:0] RST_BRIGHTNESS = 8'd200;

  // One scaling job: level = floor(colour * bright * weight / den)
  typedef struct packed {
    logic        start;
    logic [6:0]  weight;
    logic [14:0] den;
  } scl_job_t;

endpackage

`default_nettype wire

FILE: rtl/core/lra_scaler.sv
// ----------------------------------------------------------------------------
// lra_scaler: bit-serial colour scaler
// Computes floor(colour * bright * weight / den) with a shift-add multiply
// over the weight bits, then a restoring divide, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lra_scaler (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lra_pkg::scl_job_t job_i,
  input  wire logic [7:0]       colour_i,
  input  wire logic [7:0]       bright_i,
  output logic                  done_o,
  output logic [7:0]            level_o
);

  typedef enum logic [2:0] {
    SC_IDLE = 3'b001,
    SC_MUL  = 3'b010,
    SC_DIV  = 3'b100
  } scl_state_e;

  scl_state_e  state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [15:0] cb_q, cb_d;
  logic [6:0]  w_q, w_d;
  logic [22:0] acc_q, acc_d;
  logic [22:0] dsr_q, dsr_d;
  logic [7:0]  quo_q, quo_d;

  // Sequence load, multiply and divide steps
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    cb_d    = cb_q;
    w_d     = w_q;
    acc_d   = acc_q;
    dsr_d   = dsr_q;
    quo_d   = quo_q;
    case (state_q)
      SC_IDLE: begin
        if (job_i.start) begin
          cb_d    = colour_i * bright_i;
          w_d     = job_i.weight;
          acc_d   = '0;
          dsr_d   = {1'b0, job_i.den, 7'b0};
          quo_d   = '0;
          cnt_d   = '0;
          state_d = SC_MUL;
        end
      end
      SC_MUL: begin
        // add the product row for the current weight bit, MSB first
        acc_d = {acc_q[21:0], 1'b0} + (w_q[6] ? {7'b0, cb_q} : 23'd0);
        w_d   = {w_q[5:0], 1'b0};
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd6) begin
          cnt_d   = '0;
          state_d = SC_DIV;
        end
      end
      SC_DIV: begin
        // take off the shifted divisor where it fits
        if (acc_q >= dsr_q) begin
          acc_d = acc_q - dsr_q;
          quo_d = {quo_q[6:0], 1'b1};
        end else begin
          quo_d = {quo_q[6:0], 1'b0};
        end
        dsr_d = {1'b0, dsr_q[22:1]};
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          cnt_d   = '0;
          done_d  = 1'b1;
          state_d = SC_IDLE;
        end
      end
      default: begin
        state_d = SC_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cb_q  <= cb_d;
    w_q   <= w_d;
    acc_q <= acc_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o  = done_q;
  assign level_o = quo_q;

endmodule

`default_nettype wire

FILE: rtl/core/led_ring_animation_engine.sv
// ----------------------------------------------------------------------------
// led_ring_animation_engine: frame sequencer for an LED ring
// Turns each frame request into one colour item per LED, in ring order,
// for the solid, spinner and breathe patterns, plus the frame hold time.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | sink      | in_valid_i / in_ready_o | frame_request_i
//  out     | source    | out_valid_o/out_ready_i | led_index_o, red/green/blue_out_o,
//          |           |                         | hold_ms_o, last_pixel_o
//  cfg     | sink      | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
//  Each LED passes through one load, seven multiply steps and eight divide
//  steps in the bit-serial scalers, and one output load; the next LED loads
//  on the edge that hands off the current item.
//  A frame holds the input off until its last item is taken; a request of 0 leaves the input ready.
//  Reset is asynchronous and active low and loads the register defaults.
//  A stalled output item holds the sequencer; no new item enters mid-frame.
// ----------------------------------------------------------------------------
`default_nettype none

module led_ring_animation_engine #(
  parameter int RING_LEDS = 12
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       frame_request_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      led_index_o,
  output logic [7:0]      red_out_o,
  output logic [7:0]      green_out_o,
  output logic [7:0]      blue_out_o,
  output logic [5:0]      hold_ms_o,
  output logic            last_pixel_o,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i
);

  localparam int IdxW = $clog2(RING_LEDS);
  localparam logic [IdxW:0]   RingN   = (IdxW + 1)'(RING_LEDS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(RING_LEDS - 1);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_CALC = 3'b010,
    T_SEND = 3'b100
  } top_state_e;

  top_state_e state_q, state_d;

  logic       lamp_on_q;
  logic [3:0] pattern_q;
  logic [7:0] base_red_q, base_green_q, base_blue_q, bright_q;

  logic [IdxW-1:0] idx_q, idx_d, nxt_idx;
  logic [IdxW-1:0] head_q, head_d;
  logic [6:0]      level_q, level_d;
  logic            rising_q, rising_d;

  logic [3:0] led_index_q;
  logic [7:0] red_q, green_q, blue_q;
  logic [5:0] hold_q;
  logic       last_q;

  logic [3:0]  pat;
  logic [5:0]  hold;
  logic [14:0] den;
  logic [6:0]  weight;
  logic [IdxW:0] diff, trail;
  logic [IdxW+3:0] idx_ext;
  logic        in_acc, frame_go, out_acc, is_last, next_px, all_done;
  logic [7:0]  red_lvl, green_lvl, blue_lvl;
  logic        red_done, green_done, blue_done;
  logic [6:0]  lvl_up;
  lra_pkg::scl_job_t job;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lamp_on_q    <= lra_pkg::RST_LAMP_ON;
      pattern_q    <= lra_pkg::RST_PATTERN;
      base_red_q   <= lra_pkg::RST_BASE_RED;
      base_green_q <= lra_pkg::RST_BASE_GREEN;
      base_blue_q  <= lra_pkg::RST_BASE_BLUE;
      bright_q     <= lra_pkg::RST_BRIGHTNESS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lra_pkg::CFG_LAMP_ON:    lamp_on_q    <= cfg_wdata_i[0];
        lra_pkg::CFG_PATTERN:    pattern_q    <= cfg_wdata_i[3:0];
        lra_pkg::CFG_BASE_RED:   base_red_q   <= cfg_wdata_i;
        lra_pkg::CFG_BASE_GREEN: base_green_q <= cfg_wdata_i;
        lra_pkg::CFG_BASE_BLUE:  base_blue_q  <= cfg_wdata_i;
        lra_pkg::CFG_BRIGHTNESS: bright_q     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Handshakes
  assign in_ready_o  = (state_q == T_IDLE);
  assign out_valid_o = (state_q == T_SEND);
  assign in_acc      = in_valid_i && in_ready_o;
  assign frame_go    = in_acc && frame_request_i;
  assign out_acc     = out_valid_o && out_ready_i;
  assign is_last     = (idx_q == LastIdx);
  assign next_px     = out_acc && !is_last;
  assign all_done    = red_done && green_done && blue_done;

  // Index of the LED whose scaling starts now
  assign nxt_idx = frame_go ? '0 : idx_q + 1'b1;

  // Spinner distance behind the head, modulo the ring size
  assign diff  = {1'b0, nxt_idx} - {1'b0, head_q};
  assign trail = (nxt_idx >= head_q) ? diff : diff + RingN;

  // Pattern, hold time, denominator and weight of the next LED
  assign pat = lamp_on_q ? pattern_q : 4'd0;
  always_comb begin
    case (pat)
      lra_pkg::PAT_SOLID: begin
        hold   = lra_pkg::HOLD_SOLID;
        den    = lra_pkg::DEN_UNIT;
        weight = 7'd1;
      end
      lra_pkg::PAT_SPIN: begin
        hold   = lra_pkg::HOLD_SPIN;
        den    = lra_pkg::DEN_SPIN;
        weight = (trail < (IdxW + 1)'(lra_pkg::TAIL_LEN)) ?
                 lra_pkg::TAIL_LEN - 7'(trail) : 7'd0;
      end
      lra_pkg::PAT_BREATHE: begin
        hold   = lra_pkg::HOLD_BREATHE;
        den    = lra_pkg::DEN_BREATHE;
        weight = level_q;
      end
      default: begin
        hold   = lra_pkg::HOLD_DARK;
        den    = lra_pkg::DEN_UNIT;
        weight = 7'd0;
      end
    endcase
  end

  assign job.start  = frame_go || next_px;
  assign job.weight = weight;
  assign job.den    = den;

  // One scaler per colour channel
  lra_scaler u_scl_red (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (job),
    .colour_i (base_red_q),
    .bright_i (bright_q),
    .done_o   (red_done),
    .level_o  (red_lvl)
  );

  lra_scaler u_scl_green (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (job),
    .colour_i (base_green_q),
    .bright_i (bright_q),
    .done_o   (green_done),
    .level_o  (green_lvl)
  );

  lra_scaler u_scl_blue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (job),
    .colour_i (base_blue_q),
    .bright_i (bright_q),
    .done_o   (blue_done),
    .level_o  (blue_lvl)
  );

  // Breathe level stepped up, clamped at the maximum level
  assign lvl_up = (level_q + lra_pkg::LEVEL_STEP > lra_pkg::LEVEL_MAX) ?
                  lra_pkg::LEVEL_MAX : level_q + lra_pkg::LEVEL_STEP;

  // Sequence the frame and advance pattern state after its last item
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    head_d   = head_q;
    level_d  = level_q;
    rising_d = rising_q;
    case (state_q)
      T_IDLE: begin
        if (frame_go) begin
          idx_d   = nxt_idx;
          state_d = T_CALC;
        end
      end
      T_CALC: begin
        if (all_done) begin
          state_d = T_SEND;
        end
      end
      T_SEND: begin
        if (next_px) begin
          idx_d   = nxt_idx;
          state_d = T_CALC;
        end else if (out_acc) begin
          state_d = T_IDLE;
          if (pat == lra_pkg::PAT_SPIN) begin
            head_d = (head_q == LastIdx) ? '0 : head_q + 1'b1;
          end
          if (pat == lra_pkg::PAT_BREATHE) begin
            if (rising_q) begin
              level_d = lvl_up;
              if (lvl_up >= lra_pkg::LEVEL_MAX) begin
                rising_d = 1'b0;
              end
            end else begin
              level_d = (level_q < lra_pkg::LEVEL_STEP) ?
                        7'd0 : level_q - lra_pkg::LEVEL_STEP;
              if (level_d == 7'd0) begin
                rising_d = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_IDLE;
      idx_q    <= '0;
      head_q   <= '0;
      level_q  <= '0;
      rising_q <= 1'b1;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      head_q   <= head_d;
      level_q  <= level_d;
      rising_q <= rising_d;
    end
  end

  // Capture the finished item into the output register
  assign idx_ext = {4'b0, idx_q};
  always_ff @(posedge clk_i) begin
    if (state_q == T_CALC && all_done) begin
      led_index_q <= idx_ext[3:0];
      red_q       <= red_lvl;
      green_q     <= green_lvl;
      blue_q      <= blue_lvl;
      hold_q      <= hold;
      last_q      <= is_last;
    end
  end

  assign led_index_o  = led_index_q;
  assign red_out_o    = red_q;
  assign green_out_o  = green_q;
  assign blue_out_o   = blue_q;
  assign hold_ms_o    = hold_q;
  assign last_pixel_o = last_q;

  // Checks
  a_scalers_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (red_done == green_done) && (red_done == blue_done))
    else $error("colour scalers out of step");

  a_done_only_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_done |-> (state_q == T_CALC))
    else $error("scaler finished outside a calculation");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_pixel_o) |=> in_ready_o)
    else $error("frame did not end after its last item");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= lra_pkg::LEVEL_MAX)
    else $error("breathe level out of range");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LastIdx)
    else $error("spinner head off the ring");

endmodule

`default_nettype wire

FILE: tb/ring_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_frame_checker: pixel predictor and comparator for the LED ring engine
// Mirrors the register file and the spinner and breathe state from the
// observed register writes and frame requests. Queues the pixels each request
// must produce and checks every accepted output item against the oldest one.
// ----------------------------------------------------------------------------
module ring_frame_checker #(
  parameter int RING_LEDS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        frame_request_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  led_index_i,
  input  logic [7:0]  red_out_i,
  input  logic [7:0]  green_out_i,
  input  logic [7:0]  blue_out_i,
  input  logic [5:0]  hold_ms_i,
  input  logic        last_pixel_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned backlog_o,
  output int unsigned pixels_checked_o
);

  typedef struct packed {
    logic [3:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [5:0] hold;
    logic       last;
  } pixel_t;

  pixel_t pixels_due[$];

  // Mirrored registers
  logic       lamp_on;
  logic [3:0] pattern_sel;
  logic [7:0] base_r;
  logic [7:0] base_g;
  logic [7:0] base_b;
  logic [7:0] bright;

  // Mirrored animation state
  int unsigned head;
  logic [6:0]  level;
  logic        rising;

  // Exact floor(colour * gain * weight / den), never above 255
  function automatic logic [7:0] dim_channel(logic [7:0] colour, logic [7:0] gain,
                                             int unsigned weight, int unsigned den);
    int unsigned prod;
    prod = colour * gain * weight;
    return 8'(prod / den);
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t      want;
    int unsigned wt;
    int unsigned den;
    int unsigned trail;
    int unsigned nxt;
    logic [5:0]  hold;
    logic        spin;
    logic        breathe;
    if (!rst_ni) begin
      lamp_on          = lra_pkg::RST_LAMP_ON;
      pattern_sel      = lra_pkg::RST_PATTERN;
      base_r           = lra_pkg::RST_BASE_RED;
      base_g           = lra_pkg::RST_BASE_GREEN;
      base_b           = lra_pkg::RST_BASE_BLUE;
      bright           = lra_pkg::RST_BRIGHTNESS;
      head             = 0;
      level            = '0;
      rising           = 1'b1;
      fail_count_o     = 0;
      pixels_checked_o = 0;
      pixels_due.delete();
      backlog_o <= 0;
    end else begin
      // Follow register writes; indexes past the last register are dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lra_pkg::CFG_LAMP_ON:    lamp_on     = cfg_wdata_i[0];
          lra_pkg::CFG_PATTERN:    pattern_sel = cfg_wdata_i[3:0];
          lra_pkg::CFG_BASE_RED:   base_r      = cfg_wdata_i;
          lra_pkg::CFG_BASE_GREEN: base_g      = cfg_wdata_i;
          lra_pkg::CFG_BASE_BLUE:  base_b      = cfg_wdata_i;
          lra_pkg::CFG_BRIGHTNESS: bright      = cfg_wdata_i;
          default: ;
        endcase
      end

      // Check each accepted pixel against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (pixels_due.size() == 0) begin
          $error("pixel item for LED %0d arrived with no frame outstanding", led_index_i);
          fail_count_o++;
        end else begin
          want = pixels_due.pop_front();
          compare_field("led_index", want.index, led_index_i);
          compare_field("red_out", want.red, red_out_i);
          compare_field("green_out", want.green, green_out_i);
          compare_field("blue_out", want.blue, blue_out_i);
          compare_field("hold_ms", want.hold, hold_ms_i);
          compare_field("last_pixel", want.last, last_pixel_i);
          pixels_checked_o++;
        end
      end

      // Predict a full frame for each accepted request; an empty one does nothing
      if (in_valid_i && in_ready_i && frame_request_i) begin
        wt      = 0;
        den     = lra_pkg::DEN_UNIT;
        hold    = lra_pkg::HOLD_DARK;
        spin    = 1'b0;
        breathe = 1'b0;
        if (lamp_on) begin
          case (pattern_sel)
            lra_pkg::PAT_SOLID: begin
              wt   = 1;
              hold = lra_pkg::HOLD_SOLID;
            end
            lra_pkg::PAT_SPIN: begin
              den  = lra_pkg::DEN_SPIN;
              hold = lra_pkg::HOLD_SPIN;
              spin = 1'b1;
            end
            lra_pkg::PAT_BREATHE: begin
              wt      = (level > lra_pkg::LEVEL_MAX) ? lra_pkg::LEVEL_MAX : level;
              den     = lra_pkg::DEN_BREATHE;
              hold    = lra_pkg::HOLD_BREATHE;
              breathe = 1'b1;
            end
            default: ;
          endcase
        end

        for (int i = 0; i < RING_LEDS; i++) begin
          // Spinner tail fades over the LEDs trailing the head
          if (spin) begin
            trail = (i + RING_LEDS - head) % RING_LEDS;
            wt    = (trail < lra_pkg::TAIL_LEN) ? lra_pkg::TAIL_LEN - trail : 0;
          end
          want.index = 4'(i);
          want.red   = dim_channel(base_r, bright, wt, den);
          want.green = dim_channel(base_g, bright, wt, den);
          want.blue  = dim_channel(base_b, bright, wt, den);
          want.hold  = hold;
          want.last  = (i == RING_LEDS - 1);
          pixels_due.push_back(want);
        end

        // Advance only the pattern that drew this frame
        if (spin) begin
          head = (head + 1) % RING_LEDS;
        end else if (breathe) begin
          if (rising) begin
            nxt = wt + lra_pkg::LEVEL_STEP;
            if (nxt >= lra_pkg::LEVEL_MAX) begin
              nxt    = lra_pkg::LEVEL_MAX;
              rising = 1'b0;
            end
          end else begin
            nxt = (wt < lra_pkg::LEVEL_STEP) ? 0 : wt - lra_pkg::LEVEL_STEP;
            if (nxt == 0) begin
              rising = 1'b1;
            end
          end
          level = 7'(nxt);
        end
      end

      backlog_o <= pixels_due.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the LED ring animation engine
// Runs a directed pass over the register extremes, every pattern and the dark
// and masking cases, then random setting phases with frame requests. Both
// channels idle at random; a side checker predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb;

  localparam int RING_LEDS     = 12;
  localparam int RANDOM_FRAMES = 270;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 17 * RING_LEDS;
  localparam int STALL_LIMIT   = 2000;

  // Pattern codes with no animation behind them
  localparam logic [3:0] PAT_DARK     = 4'd0;
  localparam logic [3:0] PAT_SPARE    = 4'd3;
  localparam logic [3:0] PAT_PRESET_A = 4'd10;
  localparam logic [3:0] PAT_PRESET_B = 4'd11;
  localparam logic [3:0] PAT_ALL_ONES = 4'd15;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       frame_request_i = 1'b0;
  logic       out_ready_i     = 1'b0;
  logic       cfg_we_i        = 1'b0;
  logic [2:0] cfg_idx_i       = '0;
  logic [7:0] cfg_wdata_i     = '0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [3:0] led_index_o;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;
  logic [5:0] hold_ms_o;
  logic       last_pixel_o;

  int unsigned check_failures;
  int unsigned pixels_backlog;
  int unsigned pixels_checked;
  int unsigned frames_requested = 0;
  int unsigned empty_requests   = 0;
  int unsigned reg_writes       = 0;
  int unsigned setting_phases   = 0;
  int unsigned quiet_cycles     = 0;
  logic        quiet_in         = 1'b0;
  logic        quiet_out        = 1'b0;

  led_ring_animation_engine #(
    .RING_LEDS(RING_LEDS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .frame_request_i(frame_request_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .led_index_o    (led_index_o),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .hold_ms_o      (hold_ms_o),
    .last_pixel_o   (last_pixel_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  ring_frame_checker #(
    .RING_LEDS(RING_LEDS)
  ) frame_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .frame_request_i (frame_request_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .led_index_i     (led_index_o),
    .red_out_i       (red_out_o),
    .green_out_i     (green_out_o),
    .blue_out_i      (blue_out_o),
    .hold_ms_i       (hold_ms_o),
    .last_pixel_i    (last_pixel_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .fail_count_o    (check_failures),
    .backlog_o       (pixels_backlog),
    .pixels_checked_o(pixels_checked)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // End the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Pixel sink: random stall before taking each item
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = quiet_out ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offer one request item after a random gap and hold it until taken
  task automatic send_frame(input logic req);
    int unsigned gap;
    gap = quiet_in ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    frame_request_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    if (req) frames_requested++;
    else empty_requests++;
  endtask

  // Drop valid and wait until every predicted pixel has been taken
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixels_backlog != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    setting_phases++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  // Colour values lean toward the ends of the range
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned random_frames;
    int unsigned burst;
    int unsigned draw;
    logic [3:0]  pat;
    logic [3:0]  dark_codes[5];
    dark_codes = '{PAT_DARK, PAT_SPARE, PAT_PRESET_A, PAT_PRESET_B, PAT_ALL_ONES};
    random_frames = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Spinner at reset defaults, then an empty request
    send_frame(1'b1);
    send_frame(1'b1);
    send_frame(1'b0);

    // Solid at full colour and full brightness, then at zero brightness
    quiesce();
    write_reg(lra_pkg::CFG_PATTERN, {4'h0, lra_pkg::PAT_SOLID});
    write_reg(lra_pkg::CFG_BASE_RED, 8'hFF);
    write_reg(lra_pkg::CFG_BASE_GREEN, 8'hFF);
    write_reg(lra_pkg::CFG_BASE_BLUE, 8'hFF);
    write_reg(lra_pkg::CFG_BRIGHTNESS, 8'hFF);
    send_frame(1'b1);
    quiesce();
    write_reg(lra_pkg::CFG_BRIGHTNESS, 8'h00);
    send_frame(1'b1);

    // Breathe, with the upper pattern bits set to show they are masked
    quiesce();
    write_reg(lra_pkg::CFG_BRIGHTNESS, 8'hFF);
    write_reg(lra_pkg::CFG_BASE_GREEN, 8'hAA);
    write_reg(lra_pkg::CFG_BASE_BLUE, 8'h55);
    write_reg(lra_pkg::CFG_PATTERN, {4'hF, lra_pkg::PAT_BREATHE});
    repeat (3) send_frame(1'b1);

    // Lamp off gives a dark frame and holds the breathe level
    quiesce();
    write_reg(lra_pkg::CFG_LAMP_ON, 8'hFE);
    send_frame(1'b1);
    quiesce();
    write_reg(lra_pkg::CFG_LAMP_ON, 8'h01);
    send_frame(1'b1);

    // Codes without a pattern, the preset codes among them
    foreach (dark_codes[k]) begin
      quiesce();
      write_reg(lra_pkg::CFG_PATTERN, {4'h0, dark_codes[k]});
      send_frame(1'b1);
    end

    // Writes past the last register are ignored
    quiesce();
    write_reg(3'(lra_pkg::CFG_BRIGHTNESS) + 3'd1, 8'hFF);
    write_reg(3'(lra_pkg::CFG_BRIGHTNESS) + 3'd2, 8'h00);
    write_reg(lra_pkg::CFG_PATTERN, {4'hA, lra_pkg::PAT_SPIN});
    send_frame(1'b1);
    send_frame(1'b1);
    send_frame(1'b0);

    // Random setting phases, each followed by a burst of requests
    while (random_frames < RANDOM_FRAMES) begin
      quiesce();
      draw = $urandom_range(0, 19);
      if (draw < 9) pat = lra_pkg::PAT_BREATHE;
      else if (draw < 13) pat = lra_pkg::PAT_SPIN;
      else if (draw < 16) pat = lra_pkg::PAT_SOLID;
      else pat = 4'($urandom);
      write_reg(lra_pkg::CFG_PATTERN, {4'($urandom), pat});
      if ($urandom_range(0, 2) == 0)
        write_reg(lra_pkg::CFG_LAMP_ON, {7'($urandom), 1'($urandom_range(0, 9) != 0)});
      if ($urandom_range(0, 1) == 0) write_reg(lra_pkg::CFG_BASE_RED, pick_byte());
      if ($urandom_range(0, 1) == 0) write_reg(lra_pkg::CFG_BASE_GREEN, pick_byte());
      if ($urandom_range(0, 1) == 0) write_reg(lra_pkg::CFG_BASE_BLUE, pick_byte());
      if ($urandom_range(0, 1) == 0) write_reg(lra_pkg::CFG_BRIGHTNESS, pick_byte());
      if ($urandom_range(0, 7) == 0)
        write_reg(3'(lra_pkg::CFG_BRIGHTNESS) + 3'($urandom_range(1, 2)), 8'($urandom));
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(4, 16);
      repeat (burst) begin
        if ($urandom_range(0, 7) == 0) begin
          send_frame(1'b0);
        end else begin
          send_frame(1'b1);
          random_frames++;
        end
      end
    end

    // Drain the last frame and let the block settle
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixels_backlog != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d frame requests and %0d empty requests, %0d pixels compared.",
             frames_requested, empty_requests, pixels_checked);
    $display("Registers were written %0d times over %0d setting phases.",
             reg_writes, setting_phases);
    if (check_failures == 0 && pixels_backlog == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
